[rtl/bts_pkg.sv]
// Shared types and constants of the bilinear texture sampler.
package bts_pkg;

  localparam int DIM_W   = 9;
  localparam int FRAC_W  = 16;
  localparam int CH_W    = 8;
  localparam int TEXEL_W = 24;
  localparam int RES_W   = 16;
  localparam int KIDX_W  = 10;
  localparam int CFG_AW  = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  // Field offsets in the input tdata word.
  localparam int OFS_TEXEL_X = 0;
  localparam int OFS_TEXEL_Y = 8;
  localparam int OFS_RED     = 16;
  localparam int OFS_GREEN   = 24;
  localparam int OFS_BLUE    = 32;
  localparam int OFS_COORD_U = 40;
  localparam int OFS_COORD_V = 72;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [CFG_AW-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TEX_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRAP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_CAP,
    ST_HORZ,
    ST_VERT
  } bts_state_t;

  typedef struct packed {
    logic mul_en;
    logic wrap_en;
  } bts_axis_ctl_t;

endpackage

[rtl/bilinear_texture_sampler_wrap.sv]
// Top level of the bilinear texture sampler with repeat wrapping.
//
// Usage: all traffic enters on the in_ stream. in_tuser selects the item kind:
// a load transfer (tuser low) writes one RGB8 texel at (texel_x, texel_y) into
// the texel memory and yields no result; a sample transfer (tuser high) carries
// coord_u and coord_v in signed Q16.16 and yields exactly one RGB result on the
// out_ stream, each channel as byte value times 256.
// Sample steps: the multiply and the index wrap, four texel reads in a row
// through the single memory port, the capture of the last read word, then the
// horizontal and the vertical lerp, whose result enters the output register.
// A load is written from idle. The block takes no new transfer until a sample
// has finished and it is idle again.
// The texture size comes from the cfg_ port (index 0 width, index 1 height) and
// must be written while the block is idle. A zero width or height returns black.
// Reset clears the size registers and the control state; texel contents are
// undefined until loaded, and every texel read by a sample must be loaded first.
// When the receiver stalls, the finished result waits in the output register;
// a following load may still be taken, while a following sample waits in its
// last stage until the output register is free.
module bilinear_texture_sampler_wrap #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [bts_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [bts_pkg::DIM_W-1:0]          cfg_wdata,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: texel_x[7:0], texel_y[15:8], red_in[23:16], green_in[31:24],
  //        blue_in[39:32], coord_u[71:40], coord_v[103:72]
  input  logic [bts_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: mode[0]
  input  logic                               in_tuser,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic [bts_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import bts_pkg::*;

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  bts_state_t state_r, state_nxt;

  logic [DIM_W-1:0]      tex_width_r, tex_height_r;
  logic [DIM_W-1:0]      w_r, h_r;
  logic [DIM_W-1:0]      w_clamp, h_clamp;
  logic                  empty_r;
  logic [FRAC_W-1:0]     u_frac_r, v_frac_r;
  logic [TEXEL_W-1:0]    c00_r, c10_r, c01_r, c11_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  in_xfer;
  logic                  smp_acc;
  logic                  ld_ok;
  logic [15:0]           tx_ext, ty_ext;
  logic                  out_free;

  bts_axis_ctl_t         axis_ctl;
  logic [XW-1:0]         ix0, ix1;
  logic [YW-1:0]         iy0, iy1;
  logic [CH_W-1:0]       fx, fy;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [TEXEL_W-1:0]    ram_wdata, ram_rdata;

  logic                  cap0, cap1, cap2, cap3, h_en, out_load;
  logic [OUT_DATA_W-1:0] blend_res;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sizes beyond the store saturate at the store size.
  assign w_clamp = (16'(tex_width_r) > 16'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : tex_width_r;
  assign h_clamp = (16'(tex_height_r) > 16'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : tex_height_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign smp_acc  = in_xfer && (in_tuser == MODE_SAMPLE);
  assign tx_ext   = {8'd0, in_tdata[OFS_TEXEL_X +: 8]};
  assign ty_ext   = {8'd0, in_tdata[OFS_TEXEL_Y +: 8]};
  assign ld_ok    = (tx_ext < 16'(MAX_WIDTH)) && (ty_ext < 16'(MAX_HEIGHT));
  assign out_free = !out_valid_r || out_tready;

  // Sample operands are held for the whole run of the item.
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      u_frac_r <= in_tdata[OFS_COORD_U +: FRAC_W];
      v_frac_r <= in_tdata[OFS_COORD_V +: FRAC_W];
      w_r      <= w_clamp;
      h_r      <= h_clamp;
      empty_r  <= (w_clamp == '0) || (h_clamp == '0);
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (smp_acc) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WRAP;
      ST_WRAP: state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_CAP;
      ST_CAP:  state_nxt = ST_HORZ;
      ST_HORZ: state_nxt = ST_VERT;
      ST_VERT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control outputs and the memory port schedule. The port writes only
  // during a load transfer in idle and reads one neighbor per cycle in
  // the read states; each read word is captured in the following state.
  always_comb begin
    in_tready        = 1'b0;
    axis_ctl.mul_en  = 1'b0;
    axis_ctl.wrap_en = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = {iy0, ix0};
    cap0             = 1'b0;
    cap1             = 1'b0;
    cap2             = 1'b0;
    cap3             = 1'b0;
    h_en             = 1'b0;
    out_load         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_addr  = {ty_ext[YW-1:0], tx_ext[XW-1:0]};
        ram_we    = in_tvalid && (in_tuser == MODE_LOAD) && ld_ok;
      end
      ST_MUL:  axis_ctl.mul_en = 1'b1;
      ST_WRAP: axis_ctl.wrap_en = 1'b1;
      ST_RD0:  ram_addr = {iy0, ix0};
      ST_RD1: begin
        ram_addr = {iy0, ix1};
        cap0     = 1'b1;
      end
      ST_RD2: begin
        ram_addr = {iy1, ix0};
        cap1     = 1'b1;
      end
      ST_RD3: begin
        ram_addr = {iy1, ix1};
        cap2     = 1'b1;
      end
      ST_CAP:  cap3 = 1'b1;
      ST_HORZ: h_en = 1'b1;
      ST_VERT: out_load = out_free;
      default: ;
    endcase
  end

  assign ram_wdata = {in_tdata[OFS_RED +: 8], in_tdata[OFS_GREEN +: 8],
                      in_tdata[OFS_BLUE +: 8]};

  bts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bts_axis #(.IW(XW)) u_axis_x (
    .clk    (clk),
    .ctl    (axis_ctl),
    .frac_i (u_frac_r),
    .dim_i  (w_r),
    .idx0_o (ix0),
    .idx1_o (ix1),
    .wt_o   (fx)
  );

  bts_axis #(.IW(YW)) u_axis_y (
    .clk    (clk),
    .ctl    (axis_ctl),
    .frac_i (v_frac_r),
    .dim_i  (h_r),
    .idx0_o (iy0),
    .idx1_o (iy1),
    .wt_o   (fy)
  );

  always_ff @(posedge clk) begin
    if (cap0) c00_r <= ram_rdata;
    if (cap1) c10_r <= ram_rdata;
    if (cap2) c01_r <= ram_rdata;
    if (cap3) c11_r <= ram_rdata;
  end

  bts_blend u_blend (
    .clk  (clk),
    .h_en (h_en),
    .c00  (c00_r),
    .c10  (c10_r),
    .c01  (c01_r),
    .c11  (c11_r),
    .fx   (fx),
    .fy   (fy),
    .res  (blend_res)
  );

  // Output register: holds a finished result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= empty_r ? '0 : blend_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/bts_ram.sv]
// Generic single-port RAM with registered read data.
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/bts_axis.sv]
// Coordinate unit for one axis: scales the coordinate fraction and wraps the two neighbor indices.
module bts_axis #(
  parameter int IW = 8
) (
  input  logic                         clk,
  input  bts_pkg::bts_axis_ctl_t       ctl,
  input  logic [bts_pkg::FRAC_W-1:0]   frac_i,
  input  logic [bts_pkg::DIM_W-1:0]    dim_i,
  output logic [IW-1:0]                idx0_o,
  output logic [IW-1:0]                idx1_o,
  output logic [bts_pkg::CH_W-1:0]     wt_o
);
  import bts_pkg::*;

  localparam int P_W = FRAC_W + DIM_W;

  logic [P_W-1:0]    prod_r;
  logic [P_W:0]      pos;
  logic [KIDX_W-1:0] k;
  logic [KIDX_W-1:0] k1;
  logic [KIDX_W-1:0] dim_ext;
  logic [KIDX_W-1:0] i0;
  logic [KIDX_W-1:0] i1;
  logic [15:0]       i0_ext;
  logic [15:0]       i1_ext;
  logic [IW-1:0]     idx0_r;
  logic [IW-1:0]     idx1_r;
  logic [CH_W-1:0]   wt_r;

  // The integer part of the coordinate contributes a multiple of the
  // dimension and drops out of the wrap, so only the fraction is scaled.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= frac_i * dim_i;
    end
  end

  // Subtract half a texel; floor lands in -1 .. dim-1.
  always_comb begin
    pos     = {1'b0, prod_r} - (P_W+1)'(32768);
    k       = pos[P_W:FRAC_W];
    k1      = k + KIDX_W'(1);
    dim_ext = {1'b0, dim_i};
    i0      = k[KIDX_W-1] ? (dim_ext - KIDX_W'(1)) : k;
    i1      = (k1 == dim_ext) ? '0 : k1;
    i0_ext  = {{(16-KIDX_W){1'b0}}, i0};
    i1_ext  = {{(16-KIDX_W){1'b0}}, i1};
  end

  always_ff @(posedge clk) begin
    if (ctl.wrap_en) begin
      idx0_r <= i0_ext[IW-1:0];
      idx1_r <= i1_ext[IW-1:0];
      wt_r   <= pos[FRAC_W-1:FRAC_W-CH_W];
    end
  end

  assign idx0_o = idx0_r;
  assign idx1_o = idx1_r;
  assign wt_o   = wt_r;

endmodule

[rtl/bts_blend.sv]
// Bilinear blend of four RGB texels: registered horizontal lerp, then vertical lerp.
module bts_blend (
  input  logic                             clk,
  input  logic                             h_en,
  input  logic [bts_pkg::TEXEL_W-1:0]      c00,
  input  logic [bts_pkg::TEXEL_W-1:0]      c10,
  input  logic [bts_pkg::TEXEL_W-1:0]      c01,
  input  logic [bts_pkg::TEXEL_W-1:0]      c11,
  input  logic [bts_pkg::CH_W-1:0]         fx,
  input  logic [bts_pkg::CH_W-1:0]         fy,
  output logic [bts_pkg::OUT_DATA_W-1:0]   res
);
  import bts_pkg::*;

  localparam int WT_W = CH_W + 1;
  localparam int H_W  = CH_W + WT_W;
  localparam int V_W  = H_W + WT_W;

  logic [WT_W-1:0] fx1;
  logic [WT_W-1:0] fx0;
  logic [WT_W-1:0] fy1;
  logic [WT_W-1:0] fy0;

  assign fx1 = {1'b0, fx};
  assign fx0 = WT_W'(256) - fx1;
  assign fy1 = {1'b0, fy};
  assign fy0 = WT_W'(256) - fy1;

  // Lane 0 is red (texel bits 23:16), lane 2 is blue.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    localparam int SH = 16 - 8 * g;

    logic [H_W-1:0] top_r;
    logic [H_W-1:0] bot_r;
    logic [V_W-1:0] vsum;

    always_ff @(posedge clk) begin
      if (h_en) begin
        top_r <= H_W'(c00[SH +: CH_W] * fx0) + H_W'(c10[SH +: CH_W] * fx1);
        bot_r <= H_W'(c01[SH +: CH_W] * fx0) + H_W'(c11[SH +: CH_W] * fx1);
      end
    end

    assign vsum = V_W'(top_r * fy0) + V_W'(bot_r * fy1);
    assign res[g*RES_W +: RES_W] = vsum[RES_W+7:8];
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the bilinear texture sampler with repeat wrapping.
`timescale 1ns / 1ps

localparam int TEX_SPAN = 256;

// One filtered color as it travels on out_tdata, red in the lowest bits.
typedef struct packed {
  logic [15:0] blue;
  logic [15:0] green;
  logic [15:0] red;
} rgb_t;

// Shadow copy of the texture and size registers, plus the colors still owed.
class texture_shadow;
  logic [23:0] texels [TEX_SPAN*TEX_SPAN];
  bit          loaded [TEX_SPAN*TEX_SPAN];
  logic [8:0]  width_q;
  logic [8:0]  height_q;
  rgb_t        pending_rgb [$];
  int          mismatches;
  int          colors_checked;

  function new();
    width_q  = '0;
    height_q = '0;
  endfunction

  function void write_reg(logic [bts_pkg::CFG_AW-1:0] idx, logic [8:0] val);
    if (idx == bts_pkg::REG_TEX_WIDTH) begin
      width_q = val;
    end else if (idx == bts_pkg::REG_TEX_HEIGHT) begin
      height_q = val;
    end
  endfunction

  function longint wrap_index(longint i, longint n);
    longint r;
    r = i % n;
    if (r < 0) begin
      r += n;
    end
    return r;
  endfunction

  function logic [15:0] blend_channel(int unsigned a00, int unsigned a10,
                                      int unsigned a01, int unsigned a11,
                                      int unsigned fx, int unsigned fy);
    int unsigned top_row;
    int unsigned bot_row;
    top_row = a00 * (256 - fx) + a10 * fx;
    bot_row = a01 * (256 - fx) + a11 * fx;
    return 16'((top_row * (256 - fy) + bot_row * fy) >> 8);
  endfunction

  function rgb_t filter_at(logic [31:0] u, logic [31:0] v);
    longint      w, h, xq, yq, ix, iy, x0, x1, y0, y1;
    int unsigned fx, fy;
    logic [23:0] c00, c10, c01, c11;
    rgb_t        r;
    r = '0;
    w = (width_q > TEX_SPAN) ? TEX_SPAN : longint'(width_q);
    h = (height_q > TEX_SPAN) ? TEX_SPAN : longint'(height_q);
    if (w == 0 || h == 0) begin
      return r;
    end
    // Texel space is offset by half a texel; the arithmetic shift floors.
    xq = longint'($signed(u)) * w - 32768;
    yq = longint'($signed(v)) * h - 32768;
    ix = xq >>> 16;
    iy = yq >>> 16;
    fx = xq[15:8];
    fy = yq[15:8];
    x0 = wrap_index(ix, w);
    x1 = wrap_index(ix + 1, w);
    y0 = wrap_index(iy, h);
    y1 = wrap_index(iy + 1, h);
    c00 = texels[int'(y0) * TEX_SPAN + int'(x0)];
    c10 = texels[int'(y0) * TEX_SPAN + int'(x1)];
    c01 = texels[int'(y1) * TEX_SPAN + int'(x0)];
    c11 = texels[int'(y1) * TEX_SPAN + int'(x1)];
    r.red   = blend_channel(c00[23:16], c10[23:16], c01[23:16], c11[23:16], fx, fy);
    r.green = blend_channel(c00[15:8], c10[15:8], c01[15:8], c11[15:8], fx, fy);
    r.blue  = blend_channel(c00[7:0], c10[7:0], c01[7:0], c11[7:0], fx, fy);
    return r;
  endfunction

  function void note_transfer(logic mode, logic [bts_pkg::IN_DATA_W-1:0] data);
    int addr;
    if (mode == bts_pkg::MODE_LOAD) begin
      addr = int'(data[bts_pkg::OFS_TEXEL_Y +: 8]) * TEX_SPAN
           + int'(data[bts_pkg::OFS_TEXEL_X +: 8]);
      texels[addr] = {data[bts_pkg::OFS_RED +: 8], data[bts_pkg::OFS_GREEN +: 8],
                      data[bts_pkg::OFS_BLUE +: 8]};
      loaded[addr] = 1'b1;
    end else begin
      pending_rgb.push_back(filter_at(data[bts_pkg::OFS_COORD_U +: 32],
                                      data[bts_pkg::OFS_COORD_V +: 32]));
    end
  endfunction

  function void check_color(logic [bts_pkg::OUT_DATA_W-1:0] data);
    rgb_t got, want;
    got = data;
    if (pending_rgb.size() == 0) begin
      $error("color %h returned with no sample waiting", data);
      mismatches++;
      return;
    end
    want = pending_rgb.pop_front();
    colors_checked++;
    if (got.red != want.red) begin
      $error("red_out: expected %0d, got %0d", want.red, got.red);
      mismatches++;
    end
    if (got.green != want.green) begin
      $error("green_out: expected %0d, got %0d", want.green, got.green);
      mismatches++;
    end
    if (got.blue != want.blue) begin
      $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  import bts_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  localparam int HOLD_CYCLES   = 300;
  // Idle margin after the last color, before the size registers are touched.
  localparam int SETTLE_CYCLES = 16;

  // The register file decodes only two of the four indexes.
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr   = '0;
  logic [DIM_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // tdata: texel_x, texel_y, red_in, green_in, blue_in, coord_u, coord_v
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // tuser: mode
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // tdata: red_out, green_out, blue_out
  logic [OUT_DATA_W-1:0] out_tdata;

  texture_shadow shadow = new();

  int items_sent;
  int loads_sent;
  int samples_sent;
  int sizes_used;
  int holds_done;
  // quiet turns off random idling on both sides; hold_rx asks the receiver
  // for one long hold-off.
  bit quiet;
  bit hold_rx;

  bilinear_texture_sampler_wrap #(
    .MAX_WIDTH (TEX_SPAN),
    .MAX_HEIGHT(TEX_SPAN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The monitors run in the active region of the rising edge, so they see the
  // values that the flops of the block see at that same edge.
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      shadow.write_reg(cfg_addr, cfg_wdata);
    end
    if (rst_n && in_tvalid && in_tready) begin
      shadow.note_transfer(in_tuser, in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      shadow.check_color(out_tdata);
    end
  end

  // Receiver: drops ready now and then, and on request holds off for a long
  // stretch so that a finished color sits in the output register and the next
  // sample backs up into the input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
        holds_done++;
      end else begin
        out_tready <= !(!quiet && $urandom_range(99) < 6);
      end
    end
  end

  // Offers one item and returns at the edge where its transfer happens. The
  // valid stays high afterwards, so the caller either sends again in the same
  // step or calls pause_until_drained.
  task automatic send_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    if (!quiet && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (mode == MODE_LOAD) begin
      loads_sent++;
    end else begin
      samples_sent++;
    end
  endtask

  // Fields that the item kind does not use carry random bits.
  function automatic logic [IN_DATA_W-1:0] random_word();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[IN_DATA_W-1:0];
  endfunction

  task automatic load_texel(input logic [7:0] x, input logic [7:0] y,
                            input logic [23:0] rgb);
    logic [IN_DATA_W-1:0] d;
    d = random_word();
    d[OFS_TEXEL_X +: 8] = x;
    d[OFS_TEXEL_Y +: 8] = y;
    d[OFS_RED +: 8]     = rgb[23:16];
    d[OFS_GREEN +: 8]   = rgb[15:8];
    d[OFS_BLUE +: 8]    = rgb[7:0];
    send_item(MODE_LOAD, d);
  endtask

  task automatic sample_at(input logic [31:0] u, input logic [31:0] v);
    logic [IN_DATA_W-1:0] d;
    d = random_word();
    d[OFS_COORD_U +: 32] = u;
    d[OFS_COORD_V +: 32] = v;
    send_item(MODE_SAMPLE, d);
  endtask

  // The first edge lets the monitor note a transfer made in this very step.
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending_rgb.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers and one index that decodes to nothing.
  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TEX_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= REG_TEX_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_addr  <= $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
    cfg_wdata <= DIM_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sizes_used++;
  endtask

  // Every texel a sample can reach lies in the wrapped region of the current
  // size, so that region is loaded completely before any sample is sent.
  task automatic fill_region();
    int cols, rows;
    cols = (shadow.width_q > TEX_SPAN) ? TEX_SPAN : int'(shadow.width_q);
    rows = (shadow.height_q > TEX_SPAN) ? TEX_SPAN : int'(shadow.height_q);
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        if (!shadow.loaded[y * TEX_SPAN + x]) begin
          load_texel(8'(x), 8'(y), 24'($urandom));
        end
      end
    end
  endtask

  // Coordinates: anywhere in Q16.16, near the origin, on whole or almost
  // whole values, and at the ends of the signed range.
  function automatic logic [31:0] random_coord();
    logic [31:0] c;
    case ($urandom_range(3))
      0: begin
        c = $urandom;
      end
      1: begin
        c = $urandom_range(32'h0006_0000) - 32'h0003_0000;
      end
      2: begin
        c = $urandom;
        c[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        case ($urandom_range(3))
          0: c = 32'h8000_0000;
          1: c = 32'h7FFF_FFFF;
          2: c = 32'h0000_0000;
          default: c = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return c;
  endfunction

  initial begin
    logic [DIM_W-1:0] w, h;
    int               cols, rows, burst, seg;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset the texture is empty, so every sample comes back black.
    sample_at(32'h8000_0000, 32'h7FFF_FFFF);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'hFFFF_FFFF, 32'h0001_0000);
    pause_until_drained();

    // Widest texture, one row high. Column 0 is black and column 255 white, so
    // the left edge blends across the wrap.
    set_size(9'd256, 9'd1);
    fill_region();
    load_texel(8'd0, 8'd0, 24'h000000);
    load_texel(8'd255, 8'd0, 24'hFFFFFF);
    load_texel(8'd255, 8'd255, 24'hFFFFFF);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h0000_0080, 32'h0000_0000);
    sample_at(32'h0000_FF80, 32'h1234_5678);
    sample_at(32'h0001_0000, 32'h0000_0000);
    sample_at(32'h0000_00C0, 32'h0000_8000);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);
    sample_at(32'h8000_0000, 32'hFFFF_FFFF);
    pause_until_drained();

    // One column, with a height above the store that must saturate.
    set_size(9'd1, 9'd511);
    fill_region();
    sample_at(32'h5555_5555, 32'h0000_0000);
    sample_at(32'h0000_0000, 32'h7FFF_FFFF);
    sample_at(32'hFFFF_FFFF, 32'h8000_0000);
    pause_until_drained();

    // Oversized width on the loaded row, then the tallest legal column.
    set_size(9'd400, 9'd1);
    sample_at(32'h0000_8000, 32'hABCD_0000);
    sample_at(32'hFFFF_0000, 32'h0000_0001);
    pause_until_drained();
    set_size(9'd1, 9'd256);
    sample_at(32'h1234_5678, 32'h0000_FF80);
    sample_at(32'h0000_0000, 32'hFFFF_FFFF);
    pause_until_drained();

    // A zero in either dimension means black regardless of the other.
    set_size(9'd0, 9'd7);
    sample_at(32'h0000_8000, 32'h0000_8000);
    pause_until_drained();
    set_size(9'd5, 9'd0);
    sample_at(32'h0000_8000, 32'h0000_8000);
    pause_until_drained();

    // Random segments: each picks a size, completes the region it can reach,
    // then mixes texel loads with samples. Every segment ends by draining the
    // block before its sizes change.
    seg = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(5))
        0, 1: begin
          w = DIM_W'($urandom_range(12, 1));
          h = DIM_W'($urandom_range(12, 1));
        end
        2: begin
          w = DIM_W'($urandom_range(511, 1));
          h = 9'd1;
        end
        3: begin
          w = 9'd1;
          h = DIM_W'($urandom_range(511, 1));
        end
        4: begin
          if ($urandom_range(1)) begin
            w = 9'd0;
            h = DIM_W'($urandom);
          end else begin
            w = DIM_W'($urandom);
            h = 9'd0;
          end
        end
        default: begin
          w = DIM_W'($urandom_range(2, 1));
          h = DIM_W'($urandom_range(2, 1));
        end
      endcase
      set_size(w, h);
      fill_region();
      cols = (w > TEX_SPAN) ? TEX_SPAN : int'(w);
      rows = (h > TEX_SPAN) ? TEX_SPAN : int'(h);

      // The second segment runs against a long receiver hold-off; the third
      // runs with no idling on either side.
      quiet = (seg == 2);
      if (seg == 1) begin
        hold_rx = 1'b1;
      end

      burst = $urandom_range(100, 60);
      repeat (burst) begin
        if ($urandom_range(99) < 35) begin
          if (cols > 0 && rows > 0 && $urandom_range(1)) begin
            load_texel(8'($urandom_range(cols - 1)), 8'($urandom_range(rows - 1)),
                       24'($urandom));
          end else begin
            load_texel(8'($urandom), 8'($urandom), 24'($urandom));
          end
        end else begin
          sample_at(random_coord(), random_coord());
        end
      end
      pause_until_drained();
      quiet = 1'b0;
      seg++;
    end

    pause_until_drained();
    if (shadow.pending_rgb.size() != 0) begin
      $error("%0d samples never returned a color", shadow.pending_rgb.size());
    end
    $display("Run covered %0d transfers: %0d texel loads and %0d samples over %0d sizes.",
             items_sent, loads_sent, samples_sent, sizes_used);
    $display("Compared %0d filtered colors with %0d mismatches; %0d long receiver hold-offs.",
             shadow.colors_checked, shadow.mismatches, holds_done);
    if (shadow.mismatches == 0 && shadow.pending_rgb.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs a small fraction of this.
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

[sim.f]
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bts_axis.sv
rtl/bts_blend.sv
rtl/bilinear_texture_sampler_wrap.sv
tb/sv/tb_top.sv
